/* rtl/crbf_pkg.sv */
// shared constants for the count rate burst filter
`default_nettype none

package crbf_pkg;

    localparam int INDEX_BITS_DEFAULT = 32;
    localparam int QUEUE_DEPTH        = 4;
    localparam int COUNT_BITS         = 6;
    localparam int MAX_COUNT_BITS     = 7;
    localparam int WINDOW_BITS        = 32;
    localparam int TIME_BITS          = 64;

    localparam logic [MAX_COUNT_BITS-1:0] COUNT_CAP       = 7'd64;
    localparam logic [WINDOW_BITS-1:0]    WINDOW_RESET    = 32'd1;
    localparam logic [MAX_COUNT_BITS-1:0] MAX_COUNT_RESET = 7'd64;

    localparam logic REG_WINDOW    = 1'b0;
    localparam logic REG_MAX_COUNT = 1'b1;

endpackage

`default_nettype wire

/* rtl/count_rate_burst_filter.sv */
// top level of the count rate burst filter with its register port
//
// usage: timestamps enter on the item channel (item_valid/item_ready, one per beat,
// is_last on the final event of a stream). the front end numbers events and tracks
// the open time window; when an event closes a group holding fewer than max_count
// events (max_count capped at 64), it is queued as a start index and a count.
// the back end emits the group's indices on the event channel, one beat per cycle
// while event_ready is high, last_of_run set on the final index of the group.
// throughput: one item per cycle as long as the four-entry group queue has room;
// the event channel drains one index per cycle while event_ready is high, so long
// bursts of short groups fill the queue and then item_ready drops.
// with the back end idle, the closing item's group is written into the queue, then
// loaded into the back end registers, which present the group's first index.
// a stall on the event channel holds the current beat; the queue and then the
// item channel absorb it.
// reset clears the group state and queue, sets window_length to 1, max_count to 64.
// registers are written over the apb port, by the user only while idle (unchecked).
`default_nettype none

module count_rate_burst_filter
    import crbf_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEFAULT
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [2:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic      [31:0]          prdata,
    output logic                      pready,
    input  wire logic                 item_valid,
    output logic                      item_ready,
    input  wire logic [TIME_BITS-1:0] macro_time,
    input  wire logic                 is_last,
    output logic                      event_valid,
    input  wire logic                 event_ready,
    output logic      [31:0]          event_index,
    output logic                      last_of_run
);

    localparam int Q_WIDTH = INDEX_BITS + COUNT_BITS;

    logic [WINDOW_BITS-1:0]    window_length_reg;
    logic [MAX_COUNT_BITS-1:0] max_count_reg;
    logic                      cfg_write;

    logic                  item_fire;
    logic                  q_push, q_pop, q_full, q_empty;
    logic [INDEX_BITS-1:0] push_start;
    logic [COUNT_BITS-1:0] push_count;
    logic [Q_WIDTH-1:0]    q_out;
    logic [INDEX_BITS-1:0] cur_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        case (paddr[2])
            REG_WINDOW:    prdata = window_length_reg;
            REG_MAX_COUNT: prdata = 32'(max_count_reg);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= WINDOW_RESET;
            max_count_reg     <= MAX_COUNT_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_WINDOW)
            begin
                window_length_reg <= pwdata;
            end
            else
            begin
                max_count_reg <= pwdata[MAX_COUNT_BITS-1:0];
            end
        end
    end

    assign item_ready = !q_full;
    assign item_fire  = item_valid && item_ready;

    crbf_front #(
        .INDEX_BITS(INDEX_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .window_length(window_length_reg),
        .max_count    (max_count_reg),
        .item_fire    (item_fire),
        .macro_time   (macro_time),
        .is_last      (is_last),
        .push         (q_push),
        .push_start   (push_start),
        .push_count   (push_count)
    );

    crbf_queue #(
        .WIDTH(Q_WIDTH),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_data({push_start, push_count}),
        .pop      (q_pop),
        .pop_data (q_out),
        .full     (q_full),
        .empty    (q_empty)
    );

    crbf_back #(
        .INDEX_BITS(INDEX_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_start    (q_out[Q_WIDTH-1:COUNT_BITS]),
        .q_count    (q_out[COUNT_BITS-1:0]),
        .pop        (q_pop),
        .event_valid(event_valid),
        .event_ready(event_ready),
        .cur_index  (cur_index),
        .last_of_run(last_of_run)
    );

    assign event_index = 32'(cur_index);

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("group queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("group queue read while empty");

    a_run_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (event_valid && event_ready && !last_of_run)
        |=> (event_valid && cur_index == INDEX_BITS'($past(cur_index) + 1'b1)))
        else $error("index run broken before its last beat");

endmodule

`default_nettype wire

/* rtl/crbf_queue.sv */
// small register queue of group descriptors between front and back
`default_nettype none

module crbf_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] pop_data,
    output logic                  full,
    output logic                  empty
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    slot_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] fill_reg, fill_next;

    assign full     = (fill_reg == CNT_BITS'(DEPTH));
    assign empty    = (fill_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

/* rtl/crbf_front.sv */
// front end: indexes events, tracks the open group and queues closed groups
`default_nettype none

module crbf_front
    import crbf_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEFAULT
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [WINDOW_BITS-1:0]    window_length,
    input  wire logic [MAX_COUNT_BITS-1:0] max_count,
    input  wire logic                      item_fire,
    input  wire logic [TIME_BITS-1:0]      macro_time,
    input  wire logic                      is_last,
    output logic                           push,
    output logic      [INDEX_BITS-1:0]     push_start,
    output logic      [COUNT_BITS-1:0]     push_count
);

    logic [INDEX_BITS-1:0] group_start_index_reg, group_start_index_next;
    logic [TIME_BITS-1:0]  group_start_time_reg, group_start_time_next;
    logic [INDEX_BITS-1:0] next_event_index_reg, next_event_index_next;
    logic                  group_open_reg, group_open_next;

    logic [TIME_BITS-1:0]      diff;
    logic                      close;
    logic [INDEX_BITS-1:0]     cnt;
    logic [MAX_COUNT_BITS-1:0] lim;
    logic                      cnt_ok;

    always_comb
    begin
        diff   = macro_time - group_start_time_reg;
        close  = group_open_reg && ((diff >= TIME_BITS'(window_length)) || is_last);
        cnt    = next_event_index_reg - group_start_index_reg;
        lim    = (max_count > COUNT_CAP) ? COUNT_CAP : max_count;
        cnt_ok = (cnt[INDEX_BITS-1:MAX_COUNT_BITS] == '0)
                 && (cnt[MAX_COUNT_BITS-1:0] < lim)
                 && (cnt != '0);

        push       = item_fire && close && cnt_ok;
        push_start = group_start_index_reg;
        push_count = cnt[COUNT_BITS-1:0];

        group_start_index_next = group_start_index_reg;
        group_start_time_next  = group_start_time_reg;
        next_event_index_next  = next_event_index_reg;
        group_open_next        = group_open_reg;

        if (item_fire)
        begin
            if (close || !group_open_reg)
            begin
                group_start_index_next = next_event_index_reg;
                group_start_time_next  = macro_time;
            end
            if (is_last)
            begin
                group_open_next       = 1'b0;
                next_event_index_next = '0;
            end
            else
            begin
                group_open_next       = 1'b1;
                next_event_index_next = next_event_index_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_start_index_reg <= '0;
            group_start_time_reg  <= '0;
            next_event_index_reg  <= '0;
            group_open_reg        <= 1'b0;
        end
        else
        begin
            group_start_index_reg <= group_start_index_next;
            group_start_time_reg  <= group_start_time_next;
            next_event_index_reg  <= next_event_index_next;
            group_open_reg        <= group_open_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/crbf_back.sv */
// back end: expands queued groups into one index beat per cycle while event_ready is high
`default_nettype none

module crbf_back
    import crbf_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEFAULT
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  q_empty,
    input  wire logic [INDEX_BITS-1:0] q_start,
    input  wire logic [COUNT_BITS-1:0] q_count,
    output logic                       pop,
    output logic                       event_valid,
    input  wire logic                  event_ready,
    output logic      [INDEX_BITS-1:0] cur_index,
    output logic                       last_of_run
);

    logic                  busy_reg, busy_next;
    logic [INDEX_BITS-1:0] idx_reg, idx_next;
    logic [COUNT_BITS-1:0] remaining_reg, remaining_next;
    logic                  last_reg, last_next;
    logic                  advance;

    assign event_valid = busy_reg;
    assign cur_index   = idx_reg;
    assign last_of_run = last_reg;

    always_comb
    begin
        advance        = !busy_reg || event_ready;
        pop            = 1'b0;
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        remaining_next = remaining_reg;
        last_next      = last_reg;
        if (advance)
        begin
            if (busy_reg && !last_reg)
            begin
                idx_next       = idx_reg + 1'b1;
                remaining_next = remaining_reg - 1'b1;
                last_next      = (remaining_reg == COUNT_BITS'(2));
            end
            else if (!q_empty)
            begin
                pop            = 1'b1;
                busy_next      = 1'b1;
                idx_next       = q_start;
                remaining_next = q_count;
                last_next      = (q_count == COUNT_BITS'(1));
            end
            else
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        remaining_reg <= remaining_next;
        last_reg      <= last_next;
    end

endmodule

`default_nettype wire
